### design/hmvn_pkg.sv
// ----------------------------------------------------------------------------
// hmvn_pkg: shared types and constants of the heightmap vertex engine
// Item formats, configuration register indexes, shared-unit operation codes,
// sequencer states and arithmetic widths.
// ----------------------------------------------------------------------------
`default_nettype none

package hmvn_pkg;

    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 128;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HSCALE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VSCALE = 2'd3;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // arithmetic widths
    localparam int Y_W    = 28;     // scaled height, Q12.16
    localparam int V_W    = 29;     // vector component / multiplier operand
    localparam int PROD_W = 2 * V_W;
    localparam int SUM_W  = 58;     // sum of three squares
    localparam int NUM_W  = 64;     // shared unit numerator / radicand
    localparam int DEN_W  = 29;
    localparam int REM_W  = 33;
    localparam int RES_W  = 32;
    localparam int CNT_W  = 6;

    // result bits produced per operation
    localparam int TEX_QB  = 24;
    localparam int FACE_QB = 26;
    localparam int NORM_QB = 16;
    localparam int ROOT_B  = 29;

    localparam logic signed [15:0] NORM_ONE = 16'sd16384;
    localparam logic [16:0]        TEX_ONE  = 17'd65536;

    typedef struct packed {
        logic               kind;
        logic [6:0]         col;
        logic [6:0]         row;
        logic signed [15:0] height;
    } hmvn_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_max_y;
    } hmvn_out_t;

    typedef enum logic [1:0] {
        OP_DIV_TEX,
        OP_DIV_FACE,
        OP_DIV_NORM,
        OP_SQRT
    } hmvn_op_t;

    typedef struct packed {
        logic             start;
        hmvn_op_t         op;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } hmvn_req_t;

    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] res;
    } hmvn_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD_SCALE,
        ST_LD_BOX,
        ST_RD_ADDR,
        ST_RD_MUL,
        ST_RD_SAVE,
        ST_POS_X,
        ST_POS_Z,
        ST_TEX_U,
        ST_TEX_U_WAIT,
        ST_TEX_V,
        ST_TEX_V_WAIT,
        ST_FACE_SEL,
        ST_NORM_SEL,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQ_SUM,
        ST_ROOT,
        ST_ROOT_WAIT,
        ST_DIV,
        ST_DIV_WAIT,
        ST_OUT
    } hmvn_state_t;

endpackage

`default_nettype wire

### design/heightmap_vertex_normal_engine.sv
// ----------------------------------------------------------------------------
// heightmap_vertex_normal_engine: heightmap to terrain vertex engine
// Stores height samples and answers vertex reads with position, texture
// coordinates, unit normal and the running height bounds.
// ----------------------------------------------------------------------------
// One item is in work at a time; in_ready is high only while idle. A load
// scales the height and updates the height bounds. A read fetches and scales
// 7 grid heights (only the center when no normal is formed), forms the
// position on the multiplier and runs both texture divisions, then for each
// of the up to six adjacent faces forms the squares, does a square root and
// three divisions, and finishes with one more root and, unless the sum is
// zero, three divisions. The divisions and roots run on the shared divide /
// square-root unit, one result bit per cycle. A finished result waits in the
// output register while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_vertex_normal_engine
    import hmvn_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire hmvn_in_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output hmvn_out_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    // neighbour points around the vertex
    localparam logic [2:0] P_C  = 3'd0;
    localparam logic [2:0] P_E  = 3'd1;
    localparam logic [2:0] P_S  = 3'd2;
    localparam logic [2:0] P_W  = 3'd3;
    localparam logic [2:0] P_SW = 3'd4;
    localparam logic [2:0] P_NE = 3'd5;
    localparam logic [2:0] P_N  = 3'd6;
    localparam logic [2:0] FACE_END = 3'd6;
    localparam logic [1:0] COMP_LAST = 2'd2;

    hmvn_state_t state_reg, state_next;

    // configuration
    logic [7:0]         width_reg;
    logic [7:0]         depth_reg;
    logic [14:0]        hscale_reg;
    logic signed [15:0] vscale_reg;

    // item and sequencer
    logic [6:0]            col_reg;
    logic [6:0]            row_reg;
    logic signed [15:0]    hgt_reg;
    logic [2:0]            pt_reg;
    logic [2:0]            face_reg;
    logic [1:0]            comp_reg;
    logic                  last_pass_reg;
    logic signed [Y_W-1:0] y_reg [7];
    logic signed [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]      ssum_reg;
    logic signed [V_W-1:0] vec_reg [3];
    logic signed [V_W-1:0] acc_reg [3];
    logic [ROOT_B-1:0]     len_reg;
    logic signed [15:0]    nrm_reg [3];
    logic signed [31:0]    px_reg;
    logic signed [31:0]    pz_reg;
    logic [16:0]           tu_reg;
    logic [16:0]           tv_reg;
    logic signed [31:0]    min_reg;
    logic signed [31:0]    max_reg;
    logic                  out_valid_reg;
    hmvn_out_t             out_reg;

    // datapath
    logic [7:0]            w_eff;
    logic [7:0]            d_eff;
    logic [7:0]            mw;
    logic [7:0]            md;
    logic [22:0]           s_val;
    logic                  norm_en;
    logic                  c_lo, c_hi, r_lo, r_hi;
    logic [7:0]            face_on;
    logic signed [V_W-1:0] fx, fz;
    logic signed [V_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [Y_W-1:0] y_new;
    logic [V_W-1:0]        mag;
    logic [RES_W-1:0]      q;
    logic [NORM_QB-1:0]    q_clip;
    logic signed [V_W-1:0] q_face;
    logic                  in_fire;
    logic                  ld_ok;
    logic                  rd_inside;
    logic [2:0]            pt_last;
    logic [31:0]           pxx, pzz;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [15:0]           ram_rdata;
    hmvn_req_t             req;
    hmvn_rsp_t             rsp;

    function automatic logic signed [V_W-1:0] ydiff(
        input logic signed [Y_W-1:0] a,
        input logic signed [Y_W-1:0] b
    );
        return {a[Y_W-1], a} - {b[Y_W-1], b};
    endfunction

    // clamped grid size and derived values
    assign w_eff = (width_reg == 8'd0) ? 8'd1 :
                   (32'(width_reg) > MAX_COLS) ? 8'(MAX_COLS) : width_reg;
    assign d_eff = (depth_reg == 8'd0) ? 8'd1 :
                   (32'(depth_reg) > MAX_ROWS) ? 8'(MAX_ROWS) : depth_reg;
    assign mw    = (w_eff > 8'd1) ? (w_eff - 8'd1) : 8'd1;
    assign md    = (d_eff > 8'd1) ? (d_eff - 8'd1) : 8'd1;
    assign s_val = {hscale_reg, 8'b0};

    assign c_lo    = (col_reg != 7'd0);
    assign r_lo    = (row_reg != 7'd0);
    assign c_hi    = (({1'b0, col_reg} + 8'd1) < w_eff);
    assign r_hi    = (({1'b0, row_reg} + 8'd1) < d_eff);
    assign norm_en = ({1'b0, col_reg} < w_eff) && ({1'b0, row_reg} < d_eff)
                     && (hscale_reg != 15'd0);
    assign face_on = {2'b00, c_lo && r_lo, c_hi && r_lo, c_hi && r_lo,
                      c_lo && r_hi, c_lo && r_hi, c_hi && r_hi};
    assign pt_last = norm_en ? P_N : P_C;
    assign rd_inside = (32'(col_reg) < MAX_COLS) && (32'(row_reg) < MAX_ROWS);

    assign in_fire = in_valid && in_ready;
    assign ld_ok   = (32'(in_data.col) < MAX_COLS) && (32'(in_data.row) < MAX_ROWS);
    assign wr_addr = AW'(32'(in_data.row) * 32'(MAX_COLS) + 32'(in_data.col));

    // face direction vectors, x and z parts
    always_comb
    begin
        case (face_reg)
            3'd0:
            begin
                fx = ydiff(y_reg[P_C], y_reg[P_E]);
                fz = ydiff(y_reg[P_C], y_reg[P_S]);
            end
            3'd1:
            begin
                fx = ydiff(y_reg[P_W], y_reg[P_C]);
                fz = ydiff(y_reg[P_W], y_reg[P_SW]);
            end
            3'd2:
            begin
                fx = ydiff(y_reg[P_SW], y_reg[P_S]);
                fz = ydiff(y_reg[P_C], y_reg[P_S]);
            end
            3'd3:
            begin
                fx = ydiff(y_reg[P_N], y_reg[P_NE]);
                fz = ydiff(y_reg[P_N], y_reg[P_C]);
            end
            3'd4:
            begin
                fx = ydiff(y_reg[P_C], y_reg[P_E]);
                fz = ydiff(y_reg[P_NE], y_reg[P_E]);
            end
            default:
            begin
                fx = ydiff(y_reg[P_W], y_reg[P_C]);
                fz = ydiff(y_reg[P_N], y_reg[P_C]);
            end
        endcase
    end

    // grid address of the point being fetched
    always_comb
    begin
        pxx = 32'(col_reg);
        pzz = 32'(row_reg);
        case (pt_reg)
            P_E:  pxx = 32'(col_reg) + 32'd1;
            P_S:  pzz = 32'(row_reg) + 32'd1;
            P_W:  pxx = 32'(col_reg) - 32'd1;
            P_SW:
            begin
                pxx = 32'(col_reg) - 32'd1;
                pzz = 32'(row_reg) + 32'd1;
            end
            P_NE:
            begin
                pxx = 32'(col_reg) + 32'd1;
                pzz = 32'(row_reg) - 32'd1;
            end
            P_N:  pzz = 32'(row_reg) - 32'd1;
            default: ;
        endcase
    end
    assign rd_addr = AW'(pzz * 32'(MAX_COLS) + pxx);

    // scaled height from the product, floor of (p + 8) / 16
    assign prod_rnd = prod_reg + PROD_W'(8);
    assign y_new    = prod_rnd[Y_W+3:4];

    assign mag    = vec_reg[comp_reg][V_W-1] ? V_W'(-vec_reg[comp_reg])
                                             : V_W'(vec_reg[comp_reg]);
    assign q      = rsp.res;
    assign q_clip = (q[NORM_QB-1:0] > NORM_QB'(NORM_ONE)) ? NORM_QB'(NORM_ONE)
                                                         : q[NORM_QB-1:0];
    assign q_face = V_W'(q[FACE_QB-1:0]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.kind == KIND_READ)
                    begin
                        state_next = ST_RD_ADDR;
                    end
                    else if (ld_ok)
                    begin
                        state_next = ST_LD_SCALE;
                    end
                end
            end
            ST_LD_SCALE:   state_next = ST_LD_BOX;
            ST_LD_BOX:     state_next = ST_IDLE;
            ST_RD_ADDR:    state_next = ST_RD_MUL;
            ST_RD_MUL:     state_next = ST_RD_SAVE;
            ST_RD_SAVE:    state_next = (pt_reg == pt_last) ? ST_POS_X : ST_RD_ADDR;
            ST_POS_X:      state_next = ST_POS_Z;
            ST_POS_Z:      state_next = ST_TEX_U;
            ST_TEX_U:      state_next = ST_TEX_U_WAIT;
            ST_TEX_U_WAIT: state_next = rsp.done ? ST_TEX_V : ST_TEX_U_WAIT;
            ST_TEX_V:      state_next = ST_TEX_V_WAIT;
            ST_TEX_V_WAIT:
            begin
                if (rsp.done)
                begin
                    state_next = norm_en ? ST_FACE_SEL : ST_OUT;
                end
            end
            ST_FACE_SEL:
            begin
                if (face_reg == FACE_END)
                begin
                    state_next = ST_NORM_SEL;
                end
                else if (face_on[face_reg])
                begin
                    state_next = ST_SQ_X;
                end
            end
            ST_NORM_SEL:   state_next = ST_SQ_X;
            ST_SQ_X:       state_next = ST_SQ_Y;
            ST_SQ_Y:       state_next = ST_SQ_Z;
            ST_SQ_Z:       state_next = ST_SQ_SUM;
            ST_SQ_SUM:     state_next = ST_ROOT;
            ST_ROOT:       state_next = ST_ROOT_WAIT;
            ST_ROOT_WAIT:
            begin
                if (rsp.done)
                begin
                    // zero sum keeps the default normal
                    if (last_pass_reg && (q[ROOT_B-1:0] == '0))
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:        state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (rsp.done)
                begin
                    if (comp_reg != COMP_LAST)
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = last_pass_reg ? ST_OUT : ST_FACE_SEL;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // state outputs: handshake, multiplier operands, shared unit request
    always_comb
    begin
        in_ready  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        req.start = 1'b0;
        req.op    = OP_DIV_TEX;
        req.num   = '0;
        req.den   = '0;
        unique case (state_reg)
            ST_IDLE:     in_ready = 1'b1;
            ST_LD_SCALE:
            begin
                mul_a = V_W'(hgt_reg);
                mul_b = V_W'(vscale_reg);
            end
            ST_RD_MUL:
            begin
                mul_a = V_W'($signed(ram_rdata));
                mul_b = V_W'(vscale_reg);
            end
            ST_POS_X:
            begin
                mul_a = V_W'($signed({2'b00, col_reg, 1'b0}) - $signed({2'b00, w_eff}));
                mul_b = V_W'(hscale_reg);
            end
            ST_POS_Z:
            begin
                mul_a = V_W'($signed({2'b00, row_reg, 1'b0}) - $signed({2'b00, d_eff}));
                mul_b = V_W'(hscale_reg);
            end
            ST_SQ_X:
            begin
                mul_a = vec_reg[0];
                mul_b = vec_reg[0];
            end
            ST_SQ_Y:
            begin
                mul_a = vec_reg[1];
                mul_b = vec_reg[1];
            end
            ST_SQ_Z:
            begin
                mul_a = vec_reg[2];
                mul_b = vec_reg[2];
            end
            ST_TEX_U:
            begin
                req.start = 1'b1;
                req.op    = OP_DIV_TEX;
                req.num   = NUM_W'({col_reg, 16'b0}) + NUM_W'(mw >> 1);
                req.den   = DEN_W'(mw);
            end
            ST_TEX_V:
            begin
                req.start = 1'b1;
                req.op    = OP_DIV_TEX;
                req.num   = NUM_W'({row_reg, 16'b0}) + NUM_W'(md >> 1);
                req.den   = DEN_W'(md);
            end
            ST_ROOT:
            begin
                req.start = 1'b1;
                req.op    = OP_SQRT;
                req.num   = NUM_W'(ssum_reg);
            end
            ST_DIV:
            begin
                req.start = 1'b1;
                req.den   = DEN_W'(len_reg);
                if (last_pass_reg)
                begin
                    req.op  = OP_DIV_NORM;
                    req.num = (NUM_W'(mag) << 14) + NUM_W'(len_reg >> 1);
                end
                else
                begin
                    req.op  = OP_DIV_FACE;
                    req.num = (NUM_W'(mag) << 24) + NUM_W'(len_reg >> 1);
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= 8'd128;
            depth_reg     <= 8'd128;
            hscale_reg    <= 15'd256;
            vscale_reg    <= 16'sd256;
            min_reg       <= 32'sh7FFF_FFFF;
            max_reg       <= 32'sh8000_0000;
            out_valid_reg <= 1'b0;
            pt_reg        <= '0;
            face_reg      <= '0;
            comp_reg      <= '0;
            last_pass_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WIDTH:  width_reg  <= cfg_data[7:0];
                    REG_DEPTH:  depth_reg  <= cfg_data[7:0];
                    REG_HSCALE: hscale_reg <= cfg_data[14:0];
                    REG_VSCALE: vscale_reg <= $signed(cfg_data);
                    default: ;
                endcase
            end
            // load a new result when the register is free or being drained
            if ((state_reg == ST_OUT) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    pt_reg        <= '0;
                    face_reg      <= '0;
                    comp_reg      <= '0;
                    last_pass_reg <= 1'b0;
                end
                ST_LD_BOX:
                begin
                    if ((col_reg == 7'd0) && (row_reg == 7'd0))
                    begin
                        min_reg <= 32'(y_new);
                        max_reg <= 32'(y_new);
                    end
                    else
                    begin
                        if (32'(y_new) < min_reg)
                        begin
                            min_reg <= 32'(y_new);
                        end
                        if (32'(y_new) > max_reg)
                        begin
                            max_reg <= 32'(y_new);
                        end
                    end
                end
                ST_RD_SAVE: pt_reg <= pt_reg + 3'd1;
                ST_FACE_SEL:
                begin
                    comp_reg <= '0;
                    if ((face_reg != FACE_END) && !face_on[face_reg])
                    begin
                        face_reg <= face_reg + 3'd1;
                    end
                end
                ST_NORM_SEL: last_pass_reg <= 1'b1;
                ST_ROOT_WAIT: comp_reg <= '0;
                ST_DIV_WAIT:
                begin
                    if (rsp.done)
                    begin
                        comp_reg <= comp_reg + 2'd1;
                        if ((comp_reg == COMP_LAST) && !last_pass_reg)
                        begin
                            face_reg <= face_reg + 3'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    col_reg    <= in_data.col;
                    row_reg    <= in_data.row;
                    hgt_reg    <= in_data.height;
                    acc_reg[0] <= '0;
                    acc_reg[1] <= '0;
                    acc_reg[2] <= '0;
                    nrm_reg[0] <= '0;
                    nrm_reg[1] <= NORM_ONE;
                    nrm_reg[2] <= '0;
                end
            end
            ST_RD_SAVE: y_reg[pt_reg] <= y_new;
            ST_POS_Z:   px_reg <= {prod_reg[24:0], 7'b0};
            ST_TEX_U:   pz_reg <= {prod_reg[24:0], 7'b0};
            ST_TEX_U_WAIT:
            begin
                if (rsp.done)
                begin
                    tu_reg <= (q[TEX_QB-1:0] > TEX_QB'(TEX_ONE)) ? TEX_ONE : q[16:0];
                end
            end
            ST_TEX_V_WAIT:
            begin
                if (rsp.done)
                begin
                    tv_reg <= (q[TEX_QB-1:0] > TEX_QB'(TEX_ONE)) ? TEX_ONE : q[16:0];
                end
            end
            ST_FACE_SEL:
            begin
                vec_reg[0] <= fx;
                vec_reg[1] <= V_W'(s_val);
                vec_reg[2] <= fz;
            end
            ST_NORM_SEL:
            begin
                vec_reg[0] <= acc_reg[0];
                vec_reg[1] <= acc_reg[1];
                vec_reg[2] <= acc_reg[2];
            end
            ST_SQ_Y:   ssum_reg <= SUM_W'(unsigned'(prod_reg));
            ST_SQ_Z:   ssum_reg <= ssum_reg + SUM_W'(unsigned'(prod_reg));
            ST_SQ_SUM: ssum_reg <= ssum_reg + SUM_W'(unsigned'(prod_reg));
            ST_ROOT_WAIT:
            begin
                if (rsp.done)
                begin
                    len_reg <= q[ROOT_B-1:0];
                end
            end
            ST_DIV_WAIT:
            begin
                if (rsp.done)
                begin
                    if (last_pass_reg)
                    begin
                        nrm_reg[comp_reg] <= vec_reg[comp_reg][V_W-1]
                                             ? -$signed({1'b0, q_clip[NORM_QB-2:0]})
                                             : $signed({1'b0, q_clip[NORM_QB-2:0]});
                    end
                    else
                    begin
                        acc_reg[comp_reg] <= vec_reg[comp_reg][V_W-1]
                                             ? acc_reg[comp_reg] - q_face
                                             : acc_reg[comp_reg] + q_face;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_reg.pos_x     <= px_reg;
                    out_reg.pos_y     <= rd_inside ? 32'(y_reg[P_C]) : 32'sd0;
                    out_reg.pos_z     <= pz_reg;
                    out_reg.norm_x    <= nrm_reg[0];
                    out_reg.norm_y    <= nrm_reg[1];
                    out_reg.norm_z    <= nrm_reg[2];
                    out_reg.tex_u     <= tu_reg;
                    out_reg.tex_v     <= tv_reg;
                    out_reg.box_min_y <= min_reg;
                    out_reg.box_max_y <= max_reg;
                end
            end
            default: ;
        endcase
    end

    hmvn_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (in_fire && (in_data.kind == KIND_LOAD) && ld_ok),
        .waddr (wr_addr),
        .wdata (in_data.height),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    hmvn_divsqrt u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

### design/hmvn_ram.sv
// ----------------------------------------------------------------------------
// hmvn_ram: generic simple dual-port RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hmvn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/hmvn_divsqrt.sv
// ----------------------------------------------------------------------------
// hmvn_divsqrt: shared iterative divide / square-root unit
// Restoring shift-subtract, one result bit per cycle. Division results are
// known to fit the bit count of the operation; square root gives the floor.
// ----------------------------------------------------------------------------
`default_nettype none

module hmvn_divsqrt
    import hmvn_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire hmvn_req_t req,
    output hmvn_rsp_t      rsp
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    hmvn_op_t            op_reg, op_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]    sh_reg, sh_next;
    logic [RES_W-1:0]    res_reg, res_next;
    logic [DEN_W-1:0]    den_reg, den_next;

    logic [REM_W-1:0]    cand;
    logic [REM_W-1:0]    trial;
    logic [REM_W-1:0]    diff;
    logic                ge;

    // shared compare / subtract
    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            cand  = {rem_reg[REM_W-3:0], sh_reg[NUM_W-1:NUM_W-2]};
            trial = {res_reg[REM_W-3:0], 2'b01};
        end
        else
        begin
            cand  = {rem_reg[REM_W-2:0], sh_reg[NUM_W-1]};
            trial = REM_W'(den_reg);
        end
        ge   = (cand >= trial);
        diff = cand - trial;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        res_next  = res_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            den_next  = req.den;
            res_next  = '0;
            unique case (req.op)
                OP_DIV_TEX:
                begin
                    rem_next = REM_W'(req.num >> TEX_QB);
                    sh_next  = req.num << (NUM_W - TEX_QB);
                    cnt_next = CNT_W'(TEX_QB);
                end
                OP_DIV_FACE:
                begin
                    rem_next = REM_W'(req.num >> FACE_QB);
                    sh_next  = req.num << (NUM_W - FACE_QB);
                    cnt_next = CNT_W'(FACE_QB);
                end
                OP_DIV_NORM:
                begin
                    rem_next = REM_W'(req.num >> NORM_QB);
                    sh_next  = req.num << (NUM_W - NORM_QB);
                    cnt_next = CNT_W'(NORM_QB);
                end
                OP_SQRT:
                begin
                    rem_next = '0;
                    sh_next  = req.num << (NUM_W - 2 * ROOT_B);
                    cnt_next = CNT_W'(ROOT_B);
                end
                default:
                begin
                    rem_next = '0;
                    sh_next  = '0;
                    cnt_next = '0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff : cand;
            res_next = {res_reg[RES_W-2:0], ge};
            sh_next  = (op_reg == OP_SQRT) ? (sh_reg << 2) : (sh_reg << 1);
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        res_reg <= res_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

`default_nettype wire
